### design/mm64_pkg.sv
package mm64_pkg;

	localparam int DATA_W = 64;
	localparam int ADDR_W = 4;
	localparam int CNT_W  = $clog2(DATA_W);

	typedef logic [DATA_W-1:0] word_t;

	// Register index, taken from bit 3 of the byte address.
	localparam logic REG_MODULUS = 1'b0;

	localparam word_t MODULUS_RESET = word_t'(1);

endpackage

### design/modular_multiply_64_core.sv
// Each accepted word runs through the reduce, multiply and finish states; no new
// word is taken until the sequencer is idle again. One shared modular adder pair
// reduces the left operand one bit per step, then does the double-and-add steps.
// A finished result waits in the output register while the next word is accepted.
// Reset: arst_n is asynchronous and active low; it clears the sequencer and
// the output valid, and sets the modulus register to one.
module modular_multiply_64_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mm64_pkg::ADDR_W-1:0]   paddr,
	input  mm64_pkg::word_t               pwdata,
	output mm64_pkg::word_t               prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mm64_pkg::word_t               left_operand,
	input  mm64_pkg::word_t               right_operand,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mm64_pkg::word_t               product_mod
);
	import mm64_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	word_t            a_q;
	word_t            b_q;
	word_t            rem_q;
	word_t            acc_q;
	logic             out_valid_q;
	word_t            product_mod_q;
	word_t            modulus;
	word_t            dbl_sum;
	word_t            acc_sum;
	logic             dbl_cin;
	logic             last_step;

	mm64_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.modulus (modulus)
	);

	// During reduction this unit shifts in the next operand bit; during the
	// multiply phase it doubles the addend.
	assign dbl_cin = (state_q == ST_REDUCE) & a_q[DATA_W-1];

	mm64_modadd u_dbl (
		.x   (rem_q),
		.y   (rem_q),
		.cin (dbl_cin),
		.m   (modulus),
		.sum (dbl_sum)
	);

	mm64_modadd u_acc (
		.x   (acc_q),
		.y   (rem_q),
		.cin (1'b0),
		.m   (modulus),
		.sum (acc_sum)
	);

	assign last_step = (count_q == CNT_W'(DATA_W - 1));
	assign in_stall  = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			a_q           <= '0;
			b_q           <= '0;
			rem_q         <= '0;
			acc_q         <= '0;
			out_valid_q   <= 1'b0;
			product_mod_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						a_q     <= left_operand;
						b_q     <= right_operand;
						rem_q   <= '0;
						count_q <= '0;
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					rem_q   <= dbl_sum;
					a_q     <= {a_q[DATA_W-2:0], 1'b0};
					count_q <= count_q + CNT_W'(1);
					if (last_step) begin
						acc_q   <= '0;
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					if (b_q[0]) begin
						acc_q <= acc_sum;
					end
					rem_q   <= dbl_sum;
					b_q     <= {1'b0, b_q[DATA_W-1:1]};
					count_q <= count_q + CNT_W'(1);
					if (last_step) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						product_mod_q <= acc_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign product_mod = product_mod_q;

`ifndef ASSERT_OFF
	a_modulus_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		modulus != '0)
		else $error("modulus register holds zero");

	a_result_below_modulus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (product_mod < modulus))
		else $error("result word not below the modulus");

	a_addend_below_modulus: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT) |-> ((rem_q < modulus) && (acc_q < modulus)))
		else $error("partial values left the residue range");

	a_finish_after_mult: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT) && last_step |=> (state_q == ST_FINISH))
		else $error("sequencer skipped the finish step");
`endif

endmodule

### design/mm64_modadd.sv
module mm64_modadd (
	input  mm64_pkg::word_t x,
	input  mm64_pkg::word_t y,
	input  logic            cin,
	input  mm64_pkg::word_t m,
	output mm64_pkg::word_t sum
);
	import mm64_pkg::*;

	// Both addends lie below m, so the raw sum lies below 2m and one
	// conditional subtraction brings it back into range.
	logic [DATA_W:0] raw;
	logic [DATA_W:0] diff;

	always_comb begin
		raw  = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, cin};
		diff = raw - {1'b0, m};
		if (raw >= {1'b0, m}) begin
			sum = diff[DATA_W-1:0];
		end else begin
			sum = raw[DATA_W-1:0];
		end
	end

endmodule

### design/mm64_cfg.sv
module mm64_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mm64_pkg::ADDR_W-1:0]   paddr,
	input  mm64_pkg::word_t               pwdata,
	output mm64_pkg::word_t               prdata,
	output logic                          pready,
	output mm64_pkg::word_t               modulus
);
	import mm64_pkg::*;

	word_t modulus_q;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// A zero modulus is never stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (wr_en && (paddr[3] == REG_MODULUS) && (pwdata != '0)) begin
			modulus_q <= pwdata;
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_MODULUS: prdata = modulus_q;
			default:     prdata = '0;
		endcase
	end

	assign modulus = modulus_q;

endmodule
